@@ rtl/pcalc_pkg.sv @@
// Package for the postfix stack calculator: sizes, function and error codes,
// and the word and control structs shared by the core, the stack RAM and the ALU.
// No dependencies.
`timescale 1ns / 1ps

package pcalc_pkg;

  // Sizing of the operand stack and the Q format.
  localparam int STACK_DEPTH = 16;
  localparam int FRAC_BITS   = 16;

  localparam int DATA_W  = 32;
  localparam int FUNC_W  = 3;
  localparam int DEPTH_W = 5;
  localparam int ERR_W   = 2;
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W  = $clog2(STACK_DEPTH);
  localparam int NUM_W   = DATA_W + FRAC_BITS;
  localparam int ADD_W   = DATA_W + 2;
  localparam int ITER_W  = $clog2(NUM_W);

  // Function codes carried by the command word.
  localparam logic [FUNC_W-1:0] FN_PUSH = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ADD  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SUB  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_MUL  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DIV  = 3'd4;

  // Error codes reported with every result word.
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_DIV0  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNDER = 2'd2;
  localparam logic [ERR_W-1:0] ERR_OVER  = 2'd3;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]       stack_depth;
    logic [ERR_W-1:0]         error_code;
  } res_t;

  typedef struct packed {
    logic                     start;
    alu_op_t                  op;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

@@ rtl/pcalc_stack.sv @@
// Operand stack storage for the postfix calculator: one write port and one
// registered read port. Depends on pcalc_pkg.
`timescale 1ns / 1ps

module pcalc_stack (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [pcalc_pkg::ADDR_W-1:0]   wr_addr,
  input  logic [pcalc_pkg::DATA_W-1:0]   wr_data,
  input  logic                           rd_en,
  input  logic [pcalc_pkg::ADDR_W-1:0]   rd_addr,
  output logic [pcalc_pkg::DATA_W-1:0]   rd_data
);

  logic [pcalc_pkg::DATA_W-1:0] mem [pcalc_pkg::STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/pcalc_alu.sv @@
// Shared arithmetic unit of the postfix calculator: one adder serves saturating
// add and subtract, a shift-add signed multiply and a restoring divide.
// Depends on pcalc_pkg.
`timescale 1ns / 1ps

module pcalc_alu (
  input  logic                clk,
  input  logic                rst,
  input  pcalc_pkg::alu_req_t req,
  output pcalc_pkg::alu_rsp_t rsp
);

  localparam int DATA_W = pcalc_pkg::DATA_W;
  localparam int ADD_W  = pcalc_pkg::ADD_W;
  localparam int NUM_W  = pcalc_pkg::NUM_W;
  localparam int ITER_W = pcalc_pkg::ITER_W;
  localparam int EXT_W  = ADD_W - DATA_W;
  localparam int PROD_W = 2 * DATA_W;

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [ADD_W-1:0]  ADD_MAX  = {{EXT_W{1'b0}}, DATA_MAX};
  localparam logic signed [ADD_W-1:0]  ADD_MIN  = {{EXT_W{1'b1}}, DATA_MIN};
  localparam logic signed [PROD_W-1:0] PROD_MAX = {{DATA_W{1'b0}}, DATA_MAX};
  localparam logic signed [PROD_W-1:0] PROD_MIN = {{DATA_W{1'b1}}, DATA_MIN};
  localparam logic [NUM_W-1:0]         Q_POS_LIM = NUM_W'(DATA_MAX);
  localparam logic [NUM_W-1:0]         Q_NEG_LIM = NUM_W'({1'b0, DATA_MIN});

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  state_t                   state;
  pcalc_pkg::alu_op_t       op_q;
  logic signed [ADD_W-1:0]  hi;
  logic [NUM_W-1:0]         lo;
  logic [DATA_W-1:0]        mcand;
  logic                     neg;
  logic [ITER_W-1:0]        cnt;
  logic                     done;
  logic signed [DATA_W-1:0] result;

  logic signed [ADD_W-1:0]  add_x;
  logic signed [ADD_W-1:0]  add_y;
  logic signed [ADD_W-1:0]  add_sum;
  logic                     add_sub;
  logic                     last_mul;
  logic                     last_div;
  logic [DATA_W-1:0]        a_mag;
  logic [DATA_W-1:0]        b_mag;
  logic signed [DATA_W-1:0] add_sat;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [DATA_W-1:0] mul_sat;
  logic signed [DATA_W-1:0] div_sat;

  assign last_mul = (cnt == ITER_W'(DATA_W - 1));
  assign last_div = (cnt == ITER_W'(NUM_W - 1));

  assign a_mag = req.a[DATA_W-1] ? (~req.a + DATA_W'(1)) : req.a;
  assign b_mag = req.b[DATA_W-1] ? (~req.b + DATA_W'(1)) : req.b;

  // The single adder. In the multiply the last step subtracts, since the
  // multiplier's top bit carries negative weight. In the divide the
  // remainder is shifted left with the next numerator bit and the divisor
  // is tried against it.
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (state)
      S_IDLE: begin
        add_x   = {{EXT_W{req.a[DATA_W-1]}}, req.a};
        add_y   = {{EXT_W{req.b[DATA_W-1]}}, req.b};
        add_sub = (req.op == pcalc_pkg::ALU_SUB);
      end
      S_MUL: begin
        add_x   = hi;
        add_y   = lo[0] ? {{EXT_W{mcand[DATA_W-1]}}, mcand} : '0;
        add_sub = last_mul;
      end
      S_DIV: begin
        add_x   = {hi[ADD_W-2:0], lo[NUM_W-1]};
        add_y   = {{EXT_W{1'b0}}, mcand};
        add_sub = 1'b1;
      end
      S_FIN: begin
        add_x   = '0;
      end
      default: begin
        add_x   = '0;
      end
    endcase
    add_sum = add_sub ? (add_x - add_y) : (add_x + add_y);
  end

  always_comb begin
    if (add_sum > ADD_MAX) begin
      add_sat = DATA_MAX;
    end else if (add_sum < ADD_MIN) begin
      add_sat = DATA_MIN;
    end else begin
      add_sat = add_sum[DATA_W-1:0];
    end
  end

  // The arithmetic shift of the signed product rounds toward minus infinity.
  assign prod    = {hi[DATA_W-1:0], lo[DATA_W-1:0]};
  assign prod_sh = prod >>> pcalc_pkg::FRAC_BITS;

  always_comb begin
    if (prod_sh > PROD_MAX) begin
      mul_sat = DATA_MAX;
    end else if (prod_sh < PROD_MIN) begin
      mul_sat = DATA_MIN;
    end else begin
      mul_sat = prod_sh[DATA_W-1:0];
    end
  end

  // The quotient of the magnitudes is truncated, so negating it truncates
  // toward zero.
  always_comb begin
    if (!neg) begin
      div_sat = (lo > Q_POS_LIM) ? DATA_MAX : lo[DATA_W-1:0];
    end else begin
      div_sat = (lo > Q_NEG_LIM) ? DATA_MIN : (~lo[DATA_W-1:0] + DATA_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            op_q <= req.op;
            hi   <= '0;
            cnt  <= '0;
            unique case (req.op)
              pcalc_pkg::ALU_ADD, pcalc_pkg::ALU_SUB: begin
                result <= add_sat;
                done   <= 1'b1;
              end
              pcalc_pkg::ALU_MUL: begin
                lo    <= NUM_W'(req.b);
                mcand <= req.a;
                state <= S_MUL;
              end
              pcalc_pkg::ALU_DIV: begin
                lo    <= NUM_W'(a_mag) << pcalc_pkg::FRAC_BITS;
                mcand <= b_mag;
                neg   <= req.a[DATA_W-1] ^ req.b[DATA_W-1];
                state <= S_DIV;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_MUL: begin
          hi  <= add_sum >>> 1;
          lo  <= NUM_W'({add_sum[0], lo[DATA_W-1:1]});
          cnt <= cnt + ITER_W'(1);
          if (last_mul) begin
            state <= S_FIN;
          end
        end
        S_DIV: begin
          if (!add_sum[ADD_W-1]) begin
            hi <= add_sum;
          end else begin
            hi <= add_x;
          end
          lo  <= {lo[NUM_W-2:0], ~add_sum[ADD_W-1]};
          cnt <= cnt + ITER_W'(1);
          if (last_div) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          result <= (op_q == pcalc_pkg::ALU_MUL) ? mul_sat : div_sat;
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.result = result;

endmodule

@@ rtl/postfix_stack_calculator_core.sv @@
// Top level of the postfix stack calculator: command sequencer, top-of-stack
// register and depth count, around pcalc_stack and pcalc_alu.
// Depends on pcalc_pkg, pcalc_stack and pcalc_alu.
`timescale 1ns / 1ps

// Channel | Direction | Handshake          | Word
// cmd     | in        | cmd_valid/cmd_stall | func, push_value
// res     | out       | res_valid/res_stall | top_value, stack_depth, error_code
//
// Each command word gives exactly one result word. A push, an undefined
// function or a rejected operation needs no ALU pass; multiply takes one
// multiplier bit per cycle and divide one quotient bit per cycle through
// the shared adder, and the divide sets the worst-case rate.
// Reset empties the stack at once. A new word is taken while the previous result
// still waits in the output register; a stalled result holds only the last step.

module postfix_stack_calculator_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  pcalc_pkg::cmd_t cmd,
  output logic            res_valid,
  input  logic            res_stall,
  output pcalc_pkg::res_t res
);

  localparam int DATA_W  = pcalc_pkg::DATA_W;
  localparam int CNT_W   = pcalc_pkg::CNT_W;
  localparam int ADDR_W  = pcalc_pkg::ADDR_W;
  localparam int DEPTH_W = pcalc_pkg::DEPTH_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_CALC,
    ST_DONE
  } state_t;

  state_t                           state;
  logic [pcalc_pkg::FUNC_W-1:0]     func_q;
  logic signed [DATA_W-1:0]         pv_q;
  logic signed [DATA_W-1:0]         tos;
  logic [CNT_W-1:0]                 count;
  logic [pcalc_pkg::ERR_W-1:0]      err_q;

  logic [CNT_W-1:0]                 cnt_m1;
  logic [CNT_W-1:0]                 cnt_m2;
  logic                             is_op;
  logic                             full;
  logic                             slot_free;
  logic                             res_load;
  logic                             mem_wr;
  logic                             mem_rd;
  logic [DATA_W-1:0]                mem_rd_data;
  pcalc_pkg::alu_op_t               alu_op;
  pcalc_pkg::alu_req_t              alu_req;
  pcalc_pkg::alu_rsp_t              alu_rsp;

  assign cnt_m1    = count - CNT_W'(1);
  assign cnt_m2    = count - CNT_W'(2);
  assign full      = (count == CNT_W'(pcalc_pkg::STACK_DEPTH));
  assign is_op     = (func_q == pcalc_pkg::FN_ADD) || (func_q == pcalc_pkg::FN_SUB) ||
                     (func_q == pcalc_pkg::FN_MUL) || (func_q == pcalc_pkg::FN_DIV);
  assign slot_free = !res_valid || !res_stall;
  assign res_load  = (state == ST_DONE) && slot_free;
  assign cmd_stall = (state != ST_IDLE);

  // The top entry lives in tos; the memory holds the entries beneath it, so a
  // push spills the old top and an operation reads only the second entry.
  assign mem_wr = (state == ST_EXEC) && (func_q == pcalc_pkg::FN_PUSH) &&
                  (count != '0) && !full;
  assign mem_rd = (state == ST_EXEC);

  pcalc_stack u_stack (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (cnt_m1[ADDR_W-1:0]),
    .wr_data (tos),
    .rd_en   (mem_rd),
    .rd_addr (cnt_m2[ADDR_W-1:0]),
    .rd_data (mem_rd_data)
  );

  always_comb begin
    unique case (func_q)
      pcalc_pkg::FN_SUB: alu_op = pcalc_pkg::ALU_SUB;
      pcalc_pkg::FN_MUL: alu_op = pcalc_pkg::ALU_MUL;
      pcalc_pkg::FN_DIV: alu_op = pcalc_pkg::ALU_DIV;
      default:           alu_op = pcalc_pkg::ALU_ADD;
    endcase
  end

  assign alu_req.start = (state == ST_READ);
  assign alu_req.op    = alu_op;
  assign alu_req.a     = mem_rd_data;
  assign alu_req.b     = tos;

  pcalc_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      // A fresh result word may replace one that leaves at this same edge.
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            func_q <= cmd.func;
            pv_q   <= cmd.push_value;
            state  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          err_q <= pcalc_pkg::ERR_OK;
          state <= ST_DONE;
          if (func_q == pcalc_pkg::FN_PUSH) begin
            if (full) begin
              err_q <= pcalc_pkg::ERR_OVER;
            end else begin
              tos   <= pv_q;
              count <= count + CNT_W'(1);
            end
          end else if (is_op) begin
            // Too few entries is checked before a zero divisor.
            if (count < CNT_W'(2)) begin
              err_q <= pcalc_pkg::ERR_UNDER;
            end else if ((func_q == pcalc_pkg::FN_DIV) && (tos == '0)) begin
              err_q <= pcalc_pkg::ERR_DIV0;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state <= ST_CALC;
        end
        ST_CALC: begin
          if (alu_rsp.done) begin
            tos   <= alu_rsp.result;
            count <= cnt_m1;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            res.top_value   <= (count != '0) ? tos : '0;
            res.stack_depth <= DEPTH_W'(count);
            res.error_code  <= err_q;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A new result word only ever comes out of the completion state.
  a_res_from_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(res_valid)) |-> $past(state == ST_DONE))
    else $error("result word raised outside the completion state");

  // One command moves the depth by one entry at most.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |->
      ((count == $past(count) + CNT_W'(1)) || (count == $past(count) - CNT_W'(1))))
    else $error("stack depth jumped by more than one entry");

  // The ALU is only started once the underflow and zero-divisor checks pass.
  a_guarded_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |->
      ((count >= CNT_W'(2)) && ((func_q != pcalc_pkg::FN_DIV) || (tos != '0))))
    else $error("operation started on a rejected stack");

  // The ALU answers only while the sequencer waits for it.
  a_alu_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> (state == ST_CALC))
    else $error("ALU completion outside the wait state");

endmodule

@@ test/tb_postfix_stack_calculator_core.sv @@
// Self-checking testbench for postfix_stack_calculator_core: directed words from a table, then
// random expression sequences, checked against a Q16.16 stack predictor in this file.
// Depends on pcalc_pkg and the calculator RTL.
`timescale 1ns / 1ps

module tb_postfix_stack_calculator_core;
  import pcalc_pkg::*;

  localparam int RAND_N       = 625;
  localparam int DIR_N        = 25;
  localparam int DRAIN_AT     = 400;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 120;
  localparam int LIMIT_CYCLES = 400000;

  // Function codes with no meaning; the block must ignore them.
  localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_C = 3'd7;

  localparam logic signed [DATA_W-1:0] Q_MAX     = 32'sh7FFFFFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN     = 32'sh80000000;
  localparam logic signed [DATA_W-1:0] Q_ONE     = 32'sh00010000;
  localparam logic signed [DATA_W-1:0] Q_NEG_ONE = 32'shFFFF0000;
  localparam logic signed [DATA_W-1:0] Q_LSB     = 32'sh00000001;
  localparam logic signed [DATA_W-1:0] Q_NEG_LSB = 32'shFFFFFFFF;
  localparam logic signed [DATA_W-1:0] Q_ZERO    = 32'sh00000000;

  typedef struct packed {
    cmd_t word;
    logic known;
    res_t want;
  } dir_row_t;

  // Where known is set the result word is written out; otherwise the predictor supplies it.
  dir_row_t dir_rows [DIR_N] = '{
    '{'{FN_ADD,  Q_ZERO},    1'b1, '{Q_ZERO, 5'd0, ERR_UNDER}},
    '{'{FN_PUSH, Q_MAX},     1'b1, '{Q_MAX,  5'd1, ERR_OK}},
    '{'{FN_DIV,  Q_ZERO},    1'b1, '{Q_MAX,  5'd1, ERR_UNDER}},
    '{'{FN_PUSH, Q_MAX},     1'b1, '{Q_MAX,  5'd2, ERR_OK}},
    '{'{FN_ADD,  Q_ZERO},    1'b1, '{Q_MAX,  5'd1, ERR_OK}},
    '{'{FN_PUSH, Q_MIN},     1'b1, '{Q_MIN,  5'd2, ERR_OK}},
    '{'{FN_SUB,  Q_ZERO},    1'b1, '{Q_MAX,  5'd1, ERR_OK}},
    '{'{FN_PUSH, Q_MIN},     1'b1, '{Q_MIN,  5'd2, ERR_OK}},
    '{'{FN_PUSH, Q_MIN},     1'b1, '{Q_MIN,  5'd3, ERR_OK}},
    '{'{FN_ADD,  Q_ZERO},    1'b1, '{Q_MIN,  5'd2, ERR_OK}},
    '{'{FN_MUL,  Q_ZERO},    1'b0, '0},
    '{'{FN_PUSH, Q_ZERO},    1'b1, '{Q_ZERO, 5'd2, ERR_OK}},
    '{'{FN_DIV,  Q_MAX},     1'b1, '{Q_ZERO, 5'd2, ERR_DIV0}},
    '{'{FN_SPARE_A, Q_MAX},  1'b1, '{Q_ZERO, 5'd2, ERR_OK}},
    '{'{FN_SPARE_B, Q_MIN},  1'b1, '{Q_ZERO, 5'd2, ERR_OK}},
    '{'{FN_SPARE_C, Q_ONE},  1'b1, '{Q_ZERO, 5'd2, ERR_OK}},
    '{'{FN_MUL,  Q_ZERO},    1'b0, '0},
    '{'{FN_PUSH, Q_NEG_LSB}, 1'b0, '0},
    '{'{FN_PUSH, Q_LSB},     1'b0, '0},
    '{'{FN_MUL,  Q_ZERO},    1'b0, '0},
    '{'{FN_PUSH, Q_MIN},     1'b0, '0},
    '{'{FN_PUSH, Q_NEG_ONE}, 1'b0, '0},
    '{'{FN_DIV,  Q_ZERO},    1'b0, '0},
    '{'{FN_DIV,  Q_ZERO},    1'b0, '0},
    '{'{FN_SUB,  Q_ZERO},    1'b0, '0}
  };

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;
  logic res_valid;
  logic res_stall;
  res_t res;

  postfix_stack_calculator_core dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // Predictor state: its own copy of the operand stack.
  logic signed [DATA_W-1:0] calc_stack [STACK_DEPTH];
  int   calc_depth = 0;
  res_t pending_words [$];
  res_t want_word;
  int   fail_count = 0;
  int   words_seen = 0;
  int   cycle_count = 0;
  int   fill_goal = STACK_DEPTH;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic logic signed [DATA_W-1:0] clamp_word(logic signed [63:0] v);
    if (v > 64'sh000000007FFFFFFF) return Q_MAX;
    if (v < -64'sh0000000080000000) return Q_MIN;
    return v[DATA_W-1:0];
  endfunction

  // Applies one command word to the predictor stack and returns the result word it gives.
  function automatic res_t eval_word(cmd_t c);
    res_t r;
    logic signed [63:0] wa, wb;
    logic signed [DATA_W-1:0] q;
    logic div_zero;
    r = '0;
    q = '0;
    div_zero = 1'b0;
    r.error_code = ERR_OK;
    if (c.func == FN_PUSH) begin
      if (calc_depth >= STACK_DEPTH) begin
        r.error_code = ERR_OVER;
      end else begin
        calc_stack[calc_depth] = c.push_value;
        calc_depth++;
      end
    end else if (c.func <= FN_DIV) begin
      if (calc_depth < 2) begin
        r.error_code = ERR_UNDER;
      end else begin
        wa = calc_stack[calc_depth-2];
        wb = calc_stack[calc_depth-1];
        case (c.func)
          FN_ADD: q = clamp_word(wa + wb);
          FN_SUB: q = clamp_word(wa - wb);
          // An arithmetic shift of the signed product rounds toward minus infinity.
          FN_MUL: q = clamp_word((wa * wb) >>> FRAC_BITS);
          default: begin
            if (wb == 0) begin
              div_zero = 1'b1;
              r.error_code = ERR_DIV0;
            end else begin
              q = clamp_word((wa <<< FRAC_BITS) / wb);
            end
          end
        endcase
        if (!div_zero) begin
          calc_depth--;
          calc_stack[calc_depth-1] = q;
        end
      end
    end
    r.top_value   = (calc_depth > 0) ? calc_stack[calc_depth-1] : Q_ZERO;
    r.stack_depth = DEPTH_W'(calc_depth);
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      7:          return Q_ZERO;
      default: begin
        case ($urandom_range(0, 5))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return Q_ONE;
          3: return Q_NEG_ONE;
          4: return Q_NEG_LSB;
          default: return Q_LSB;
        endcase
      end
    endcase
  endfunction

  // Mostly well-formed expression traffic steered towards fill_goal, with some noise.
  function automatic cmd_t make_word(int d);
    cmd_t c;
    int roll;
    logic [FUNC_W-1:0] op;
    roll = $urandom_range(0, 99);
    op = FN_ADD + FUNC_W'($urandom_range(0, 3));
    c.push_value = pick_value();
    if (roll < 8)
      c.func = FUNC_W'($urandom_range(0, 7));
    else if (d < 2)
      c.func = (roll < 13) ? op : FN_PUSH;
    else if (d >= STACK_DEPTH)
      c.func = (roll < 40) ? FN_PUSH : op;
    else
      c.func = ($urandom_range(0, 99) < ((d < fill_goal) ? 70 : 30)) ? FN_PUSH : op;
    return c;
  endfunction

  // Sender: bursts of words with random gaps, one pause until all results are in.
  initial begin
    cmd_t c;
    res_t next_want;
    int burst_left;
    int gap;
    burst_left = 0;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int i = 0; i < DIR_N + RAND_N; i++) begin
      if (i == DRAIN_AT) begin
        cmd_valid <= 1'b0;
        @(negedge clk);
        while (pending_words.size() != 0) @(negedge clk);
      end else begin
        gap = 0;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
        end
        burst_left--;
        if (gap > 0) begin
          cmd_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      if (i >= DIR_N && (i - DIR_N) % 20 == 19)
        fill_goal = $urandom_range(2, STACK_DEPTH);
      c = (i < DIR_N) ? dir_rows[i].word : make_word(calc_depth);
      cmd <= c;
      cmd_valid <= 1'b1;
      @(posedge clk);
      while (cmd_stall) @(posedge clk);
      next_want = eval_word(c);
      if (i < DIR_N && dir_rows[i].known)
        pending_words.push_back(dir_rows[i].want);
      else
        pending_words.push_back(next_want);
      @(negedge clk);
    end
    cmd_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver: stall runs of varying density, and one long hold-off that backs the block up.
  initial begin
    int run_left;
    int stall_pct;
    bit held_off;
    run_left = 0;
    stall_pct = 0;
    held_off = 1'b0;
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && words_seen >= HOLD_AFTER) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        held_off = 1'b1;
      end else begin
        if (run_left == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 90;
          endcase
          run_left = $urandom_range(10, 60);
        end
        run_left--;
        res_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        fail_count++;
        $display("%0t: result word with none expected: top %h depth %0d err %0d",
                 $time, res.top_value, res.stack_depth, res.error_code);
      end else begin
        want_word = pending_words.pop_front();
        if (res.top_value !== want_word.top_value) begin
          fail_count++;
          $display("%0t: top_value expected %h actual %h",
                   $time, want_word.top_value, res.top_value);
        end
        if (res.stack_depth !== want_word.stack_depth) begin
          fail_count++;
          $display("%0t: stack_depth expected %0d actual %0d",
                   $time, want_word.stack_depth, res.stack_depth);
        end
        if (res.error_code !== want_word.error_code) begin
          fail_count++;
          $display("%0t: error_code expected %0d actual %0d",
                   $time, want_word.error_code, res.error_code);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule

@@ filelist.f @@
rtl/pcalc_pkg.sv
rtl/pcalc_stack.sv
rtl/pcalc_alu.sv
rtl/postfix_stack_calculator_core.sv
test/tb_postfix_stack_calculator_core.sv
